@@ hw/rtl/lst_pkg.sv @@
// ----------------------------------------------------------------------------
// lst_pkg
// Shared types and constants of the latency statistics table: the stored
// entry layout, the cleared entry value, the function codes and the
// controller commands.
// ----------------------------------------------------------------------------
package lst_pkg;

    localparam int unsigned SAMPLE_W = 32;
    localparam int unsigned TOTAL_W  = 64;
    localparam int unsigned INDEX_W  = 8;

    typedef enum logic
    {
        FUNC_RECORD = 1'b0,
        FUNC_CLEAR  = 1'b1
    } func_t;

    typedef struct packed
    {
        logic [SAMPLE_W-1:0] count;
        logic [SAMPLE_W-1:0] last;
        logic [SAMPLE_W-1:0] min;
        logic [SAMPLE_W-1:0] max;
        logic [TOTAL_W-1:0]  total;
    } entry_t;

    localparam entry_t CLEARED_ENTRY = '{
        count: '0,
        last:  '0,
        min:   '1,
        max:   '0,
        total: '0
    };

    localparam entry_t ZERO_ENTRY = '0;

    // load: capture the item and read its entry; update: modify and write back
    typedef struct packed
    {
        logic load;
        logic update;
    } lst_cmd_t;

endpackage

@@ hw/rtl/lst_ctrl.sv @@
// ----------------------------------------------------------------------------
// lst_ctrl
// Controller of the latency statistics table. Takes a command on start,
// issues load to read the entry and then update to modify and write it back.
// ----------------------------------------------------------------------------
module lst_ctrl
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    output lst_pkg::lst_cmd_t cmd
);

    typedef enum logic [1:0]
    {
        ST_IDLE   = 2'b01,
        ST_UPDATE = 2'b10
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_comb
    begin
        state_next = state_reg;
        cmd.load   = 1'b0;
        cmd.update = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_UPDATE;
                end
            end
            ST_UPDATE:
            begin
                cmd.update = 1'b1;
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign busy = (state_reg == ST_UPDATE);

    a_update_one_cycle: assert property (@(posedge clk) disable iff (!rst_n)
        busy |=> !busy)
        else $error("update phase lasted more than one cycle");

    a_load_starts_update: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load |=> cmd.update)
        else $error("accepted command not followed by update");

    a_cmd_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        !(cmd.load && cmd.update))
        else $error("load and update issued together");

endmodule

@@ hw/rtl/lst_datapath.sv @@
// ----------------------------------------------------------------------------
// lst_datapath
// Statistics memory, per-entry valid bits and the read-modify-write logic.
// An entry whose valid bit is low reads as the cleared entry.
// ----------------------------------------------------------------------------
module lst_datapath
#(
    parameter int unsigned NUM_POINTS = 16
)
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  lst_pkg::lst_cmd_t                cmd,
    input  logic                             func,
    input  logic [lst_pkg::INDEX_W-1:0]      point_index,
    input  logic [lst_pkg::SAMPLE_W-1:0]     elapsed,
    output logic                             done,
    output logic                             ignored,
    output logic [lst_pkg::SAMPLE_W-1:0]     event_count,
    output logic [lst_pkg::SAMPLE_W-1:0]     last_sample,
    output logic [lst_pkg::SAMPLE_W-1:0]     min_sample,
    output logic [lst_pkg::SAMPLE_W-1:0]     max_sample,
    output logic [lst_pkg::TOTAL_W-1:0]      sample_total
);

    localparam int unsigned ADDR_W = (NUM_POINTS > 1) ? $clog2(NUM_POINTS) : 1;

    lst_pkg::entry_t mem [NUM_POINTS];

    logic [NUM_POINTS-1:0]        valid_reg;
    logic                         func_reg;
    logic                         in_range_reg;
    logic [ADDR_W-1:0]            addr_reg;
    logic [lst_pkg::SAMPLE_W-1:0] elapsed_reg;
    lst_pkg::entry_t              rd_entry_reg;
    logic                         rd_valid_reg;
    logic                         done_reg;
    logic                         ignored_reg;
    lst_pkg::entry_t              result_reg;

    logic                         in_range;
    logic [ADDR_W-1:0]            rd_addr;
    lst_pkg::entry_t              cur_entry;
    lst_pkg::entry_t              new_entry;
    lst_pkg::entry_t              result_next;
    logic                         ignored_next;
    logic                         do_write;

    assign in_range = ({1'b0, point_index} < (lst_pkg::INDEX_W + 1)'(NUM_POINTS));
    assign rd_addr  = in_range ? ADDR_W'(point_index) : '0;

    // capture the item and read its entry
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            func_reg     <= func;
            in_range_reg <= in_range;
            addr_reg     <= rd_addr;
            elapsed_reg  <= elapsed;
            rd_entry_reg <= mem[rd_addr];
            rd_valid_reg <= valid_reg[rd_addr];
        end
    end

    always_comb
    begin
        cur_entry       = rd_valid_reg ? rd_entry_reg : lst_pkg::CLEARED_ENTRY;
        new_entry.count = cur_entry.count + 1'b1;
        new_entry.last  = elapsed_reg;
        new_entry.total = cur_entry.total + {{lst_pkg::SAMPLE_W{1'b0}}, elapsed_reg};
        new_entry.min   = (elapsed_reg < cur_entry.min) ? elapsed_reg : cur_entry.min;
        new_entry.max   = (elapsed_reg > cur_entry.max) ? elapsed_reg : cur_entry.max;
    end

    always_comb
    begin
        do_write = 1'b0;
        priority if (func_reg == lst_pkg::FUNC_CLEAR)
        begin
            ignored_next = 1'b0;
            result_next  = lst_pkg::CLEARED_ENTRY;
        end
        else if (!in_range_reg)
        begin
            ignored_next = 1'b1;
            result_next  = lst_pkg::ZERO_ENTRY;
        end
        else
        begin
            ignored_next = 1'b0;
            result_next  = new_entry;
            do_write     = cmd.update;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_write)
        begin
            mem[addr_reg] <= new_entry;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            done_reg <= cmd.update;
            if (cmd.update && (func_reg == lst_pkg::FUNC_CLEAR))
            begin
                valid_reg <= '0;
            end
            else if (do_write)
            begin
                valid_reg[addr_reg] <= 1'b1;
            end
        end
    end

    // hold the result for its strobe cycle
    always_ff @(posedge clk)
    begin
        if (cmd.update)
        begin
            ignored_reg <= ignored_next;
            result_reg  <= result_next;
        end
    end

    assign done         = done_reg;
    assign ignored      = ignored_reg;
    assign event_count  = result_reg.count;
    assign last_sample  = result_reg.last;
    assign min_sample   = result_reg.min;
    assign max_sample   = result_reg.max;
    assign sample_total = result_reg.total;

    a_done_follows_update: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.update |=> done)
        else $error("update without result strobe");

    a_ignored_is_empty: assert property (@(posedge clk) disable iff (!rst_n)
        (done && ignored) |-> (event_count == '0 && sample_total == '0))
        else $error("ignored result carries statistics");

    a_clear_drops_valid: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.update && func_reg == lst_pkg::FUNC_CLEAR) |=> (valid_reg == '0))
        else $error("clear left valid entries");

endmodule

@@ hw/rtl/latency_statistics_table.sv @@
// ----------------------------------------------------------------------------
// latency_statistics_table
// A command taken on start is loaded (its entry read) and then updated; done
// is registered from the update. A new command is taken only while busy is low;
// busy is high for the cycle in which the entry is modified and written back.
// Reset: clears all valid bits at once, so every entry reads as cleared
// (count, last, max and total zero, min all ones) right after reset.
// ----------------------------------------------------------------------------
module latency_statistics_table
#(
    parameter int unsigned NUM_POINTS = 16
)
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             start,
    output logic                             busy,
    input  logic                             func,
    input  logic [lst_pkg::INDEX_W-1:0]      point_index,
    input  logic [lst_pkg::SAMPLE_W-1:0]     elapsed,
    output logic                             done,
    output logic                             ignored,
    output logic [lst_pkg::SAMPLE_W-1:0]     event_count,
    output logic [lst_pkg::SAMPLE_W-1:0]     last_sample,
    output logic [lst_pkg::SAMPLE_W-1:0]     min_sample,
    output logic [lst_pkg::SAMPLE_W-1:0]     max_sample,
    output logic [lst_pkg::TOTAL_W-1:0]      sample_total
);

    lst_pkg::lst_cmd_t cmd;

    lst_ctrl u_ctrl
    (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .cmd   (cmd)
    );

    lst_datapath
    #(
        .NUM_POINTS (NUM_POINTS)
    )
    u_datapath
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .func         (func),
        .point_index  (point_index),
        .elapsed      (elapsed),
        .done         (done),
        .ignored      (ignored),
        .event_count  (event_count),
        .last_sample  (last_sample),
        .min_sample   (min_sample),
        .max_sample   (max_sample),
        .sample_total (sample_total)
    );

endmodule
